// ===== sv/sec_pkg.sv =====
// ----------------------------------------------------------------------------
// sec_pkg
// Shared types, widths and helpers for the sphere envelope contact pipeline.
// ----------------------------------------------------------------------------
package sec_pkg;

  // Root of a radicand below 2^68
  localparam int ROOT_W   = 34;
  localparam int RAD_W    = 2 * ROOT_W;
  // Normal magnitude quotient, at most 2^30
  localparam int Q_W      = 31;
  // Dividend |d| * 2^30 + r/2
  localparam int DVD_W    = 63;
  // Exact gap, overlap and twice the contact offset factor
  localparam int EXT_W    = 37;
  // Split of |k2| for the offset multiply
  localparam int KLO_W    = 18;
  localparam int KMAG_W   = 36;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = Q_W;
  // in regs, squares, sum, sqrt, setup, divide, normal, products, output
  localparam int PIPE_LAT = 3 + SQRT_LAT + 1 + DIV_LAT + 3;

  localparam logic [30:0] SPH_RAD_RESET = 31'd65536;
  localparam logic signed [31:0] NRM_ONE = 32'sh4000_0000;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_SPH_RAD  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        particle_radius;
    logic [30:0]        reach_radius;
  } in_data_t;

  typedef struct packed {
    logic               in_contact;
    logic signed [31:0] gap;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] overlap;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
  } out_data_t;

  // Carried alongside the square root
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] dmag;
    logic [2:0]       dneg;
    logic [30:0]      prad;
    logic [30:0]      reach;
  } geo_side_t;

  // Carried alongside the dividers and the offset multiply
  typedef struct packed {
    logic                    contact;
    logic                    rzero;
    logic signed [EXT_W-1:0] gap;
    logic signed [EXT_W-1:0] ovl;
    logic signed [EXT_W-1:0] k2;
    logic [2:0][31:0]        pos;
    logic [2:0]              dneg;
  } cnt_side_t;

  // Clamp a wide signed value to 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > 40'sh00_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/sphere_envelope_contact.sv =====
// ----------------------------------------------------------------------------
// sphere_envelope_contact
// Particle against enclosing spherical wall: gap, normal, overlap, contact.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and pulse start; a beat is taken on any edge with
//   start high and busy low. busy is low outside reset, so one particle can
//   be taken every cycle.
//   Output: each particle gives exactly one result beat, out_strobe high for
//   one cycle with out_data.
//   Results leave in the order particles came in.
//   The pipeline holds the square root (34 stages, one root bit each) and the
//   normal dividers (31 stages, one quotient bit each), plus 7 stages of
//   distance, setup, multiply and output logic.
//   Throughput: one particle per cycle.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready always high; index
//   0..2 centre x/y/z, 3 sphere radius. Write only while the pipe is empty.
//   Reset (rst_n low, synchronous): pipe valid bits clear, centre goes to 0,
//   sphere radius to 1.0.
//   The receiver cannot stall; every result beat must be taken as shown.
// ----------------------------------------------------------------------------
module sphere_envelope_contact (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sec_pkg::in_data_t   in_data,
  output logic                out_strobe,
  output sec_pkg::out_data_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import sec_pkg::*;

  // Configuration registers
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        sph_r;

  assign cfg_ready = 1'b1;
  assign busy      = !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      sph_r <= SPH_RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X: cx_r  <= cfg_data;
        REG_CENTER_Y: cy_r  <= cfg_data;
        REG_CENTER_Z: cz_r  <= cfg_data;
        REG_SPH_RAD:  sph_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage 1: offset from centre, split into sign and magnitude
  logic               v1_r;
  geo_side_t          s1_r, s1_nxt;
  logic signed [31:0] ctr [3];
  logic signed [31:0] pin [3];

  assign ctr[0] = cx_r;
  assign ctr[1] = cy_r;
  assign ctr[2] = cz_r;
  assign pin[0] = in_data.pos_x;
  assign pin[1] = in_data.pos_y;
  assign pin[2] = in_data.pos_z;

  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        m;
    s1_nxt.prad  = in_data.particle_radius;
    s1_nxt.reach = in_data.reach_radius;
    for (int i = 0; i < 3; i++) begin
      d = {pin[i][31], pin[i]} - {ctr[i][31], ctr[i]};
      m = d[32] ? (33'd0 - d) : d;
      s1_nxt.pos[i]  = pin[i];
      s1_nxt.dneg[i] = d[32];
      s1_nxt.dmag[i] = m[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    s1_r <= s1_nxt;
  end

  // Stage 2: squares
  logic        v2_r;
  geo_side_t   s2_r;
  logic [63:0] sq2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s2_r <= s1_r;
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= s1_r.dmag[i] * s1_r.dmag[i];
    end
  end

  // Stage 3: sum of squares
  logic        v3_r;
  geo_side_t   s3_r;
  logic [65:0] sum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r   <= s2_r;
    sum3_r <= 66'(sq2_r[0]) + 66'(sq2_r[1]) + 66'(sq2_r[2]);
  end

  // Square root with matching side line
  logic [ROOT_W-1:0] root;
  logic              vq_r [SQRT_LAT];
  geo_side_t         sq_r [SQRT_LAT];

  sec_isqrt #(.RW(ROOT_W)) u_isqrt (
    .clk  (clk),
    .rad  (RAD_W'(sum3_r)),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) vq_r[k] <= 1'b0;
    end else begin
      vq_r[0] <= v3_r;
      for (int k = 1; k < SQRT_LAT; k++) vq_r[k] <= vq_r[k-1];
    end
    sq_r[0] <= s3_r;
    for (int k = 1; k < SQRT_LAT; k++) sq_r[k] <= sq_r[k-1];
  end

  // Stage 4: contact test, exact gap terms, divider operands
  geo_side_t          g4;
  logic               v4_r;
  cnt_side_t          s4_r, s4_nxt;
  logic [DVD_W-1:0]   dvd4_r [3];
  logic [ROOT_W-1:0]  root4_r;

  assign g4 = sq_r[SQRT_LAT-1];

  always_comb begin
    logic signed [EXT_W-1:0] thr;
    logic signed [EXT_W-1:0] rr;
    logic signed [EXT_W-1:0] pr;
    thr = $signed({6'd0, sph_r}) - $signed({6'd0, g4.reach});
    rr  = $signed({3'd0, root});
    pr  = $signed({6'd0, g4.prad});
    s4_nxt.contact = rr > thr;
    s4_nxt.rzero   = (root == '0);
    s4_nxt.gap     = $signed({6'd0, sph_r}) - rr;
    s4_nxt.ovl     = pr - s4_nxt.gap;
    s4_nxt.k2      = pr + s4_nxt.gap;
    s4_nxt.pos     = g4.pos;
    s4_nxt.dneg    = g4.dneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vq_r[SQRT_LAT-1];
    end
    s4_r    <= s4_nxt;
    root4_r <= root;
    for (int i = 0; i < 3; i++) begin
      dvd4_r[i] <= {1'b0, g4.dmag[i], 30'd0} + DVD_W'(root[ROOT_W-1:1]);
    end
  end

  // Normal magnitude dividers
  logic [Q_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    sec_div #(.QW(Q_W), .NW(ROOT_W), .DW(DVD_W)) u_div (
      .clk (clk),
      .dvd (dvd4_r[i]),
      .den (root4_r),
      .quo (quo[i])
    );
  end

  logic      vd_r [DIV_LAT];
  cnt_side_t sd_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
    end else begin
      vd_r[0] <= v4_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
    end
    sd_r[0] <= s4_r;
    for (int k = 1; k < DIV_LAT; k++) sd_r[k] <= sd_r[k-1];
  end

  // Stage 5: signed normals and |k2|
  cnt_side_t          c5;
  logic               v5_r;
  cnt_side_t          s5_r;
  logic [Q_W-1:0]     qz5_r  [3];
  logic signed [31:0] nrm5_r [3];
  logic [KMAG_W-1:0]  kmag5_r;

  assign c5 = sd_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= vd_r[DIV_LAT-1];
    end
    s5_r    <= c5;
    kmag5_r <= c5.k2[EXT_W-1] ? KMAG_W'(-c5.k2) : KMAG_W'(c5.k2);
    for (int i = 0; i < 3; i++) begin
      qz5_r[i] <= c5.rzero ? '0 : quo[i];
      if (c5.rzero) begin
        nrm5_r[i] <= '0;
      end else if (c5.dneg[i]) begin
        nrm5_r[i] <= $signed({1'b0, quo[i]});
      end else begin
        nrm5_r[i] <= -$signed({1'b0, quo[i]});
      end
    end
  end

  // Stage 6: offset partial products
  localparam int PP_W = KLO_W + Q_W;

  logic               v6_r;
  cnt_side_t          s6_r;
  logic signed [31:0] nrm6_r [3];
  logic [PP_W-1:0]    plo6_r [3];
  logic [PP_W-1:0]    phi6_r [3];
  logic [2:0]         neg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    s6_r <= s5_r;
    for (int i = 0; i < 3; i++) begin
      nrm6_r[i] <= nrm5_r[i];
      plo6_r[i] <= PP_W'(kmag5_r[KLO_W-1:0]) * PP_W'(qz5_r[i]);
      phi6_r[i] <= PP_W'(kmag5_r[KMAG_W-1:KLO_W]) * PP_W'(qz5_r[i]);
      neg6_r[i] <= s5_r.k2[EXT_W-1] ^ nrm5_r[i][31];
    end
  end

  // Stage 7: rounded offset, contact point, saturation, output beat
  localparam int SUM_W = PP_W + KLO_W + 1;

  logic               out_strobe_r;
  out_data_t          out_data_r, out_nxt;
  logic signed [31:0] cpt [3];

  always_comb begin
    logic [SUM_W-1:0]   acc;
    logic [36:0]        mag;
    logic signed [38:0] off;
    logic signed [38:0] pt;
    for (int i = 0; i < 3; i++) begin
      acc = ({SUM_W'(phi6_r[i])} << KLO_W) + SUM_W'(plo6_r[i])
          + (SUM_W'(1) << 30);
      mag = acc[SUM_W-1:31];
      off = neg6_r[i] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      pt  = $signed({{7{s6_r.pos[i][31]}}, s6_r.pos[i]}) - off;
      cpt[i] = sat32({pt[38], pt});
    end
    out_nxt = '0;
    if (s6_r.contact) begin
      out_nxt.in_contact = 1'b1;
      out_nxt.gap        = sat32({{3{s6_r.gap[EXT_W-1]}}, s6_r.gap});
      out_nxt.overlap    = sat32({{3{s6_r.ovl[EXT_W-1]}}, s6_r.ovl});
      out_nxt.normal_x   = nrm6_r[0];
      out_nxt.normal_y   = nrm6_r[1];
      out_nxt.normal_z   = nrm6_r[2];
      out_nxt.contact_x  = cpt[0];
      out_nxt.contact_y  = cpt[1];
      out_nxt.contact_z  = cpt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v6_r;
    end
    out_data_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== sv/sec_isqrt.sv =====
// ----------------------------------------------------------------------------
// sec_isqrt
// Pipelined floor square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module sec_isqrt #(
  parameter int RW = 34
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] rem_r  [1:RW];
  logic [RW-1:0]   root_r [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [2*RW-1:0] rin;
    logic [RW-1:0]   qin;
    logic [2*RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rin = rad;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k];
      assign qin = root_r[k];
    end

    // (2*root + 2^b) * 2^b against remaining radicand
    assign trial = ({{RW{1'b0}}, qin} << (B + 1)) + ((2*RW)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rin >= trial) begin
        rem_r[k+1]  <= rin - trial;
        root_r[k+1] <= qin | (RW'(1) << B);
      end else begin
        rem_r[k+1]  <= rin;
        root_r[k+1] <= qin;
      end
    end
  end

  assign root = root_r[RW];

endmodule

// ===== sv/sec_div.sv =====
// ----------------------------------------------------------------------------
// sec_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sec_div #(
  parameter int QW = 31,
  parameter int NW = 34,
  parameter int DW = 63
) (
  input  logic          clk,
  input  logic [DW-1:0] dvd,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RMW = NW + QW;

  logic [RMW-1:0] rem_r [1:QW];
  logic [NW-1:0]  den_r [1:QW];
  logic [QW-1:0]  quo_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [RMW-1:0] rin;
    logic [NW-1:0]  nin;
    logic [QW-1:0]  qin;
    logic [RMW-1:0] sub;

    if (k == 0) begin : g_first
      assign rin = RMW'(dvd);
      assign nin = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k];
      assign nin = den_r[k];
      assign qin = quo_r[k];
    end

    assign sub = RMW'(nin) << J;

    always_ff @(posedge clk) begin
      den_r[k+1] <= nin;
      if (rin >= sub) begin
        rem_r[k+1] <= rin - sub;
        quo_r[k+1] <= qin | (QW'(1) << J);
      end else begin
        rem_r[k+1] <= rin;
        quo_r[k+1] <= qin;
      end
    end
  end

  assign quo = quo_r[QW];

endmodule

// ===== sv/sec_checker.sv =====
// ----------------------------------------------------------------------------
// sec_checker
// Port-level checks for sphere_envelope_contact, bound to the top level.
// ----------------------------------------------------------------------------
module sec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input sec_pkg::out_data_t out_data
);
  import sec_pkg::*;

  // Every result beat traces back to a start, a full pipeline latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, PIPE_LAT))
    else $error("result beat without matching start");

  // Intake never blocks
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // No contact means an all-zero result
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.in_contact) |->
      (out_data.gap == 0 && out_data.overlap == 0 && out_data.normal_x == 0 &&
       out_data.normal_y == 0 && out_data.normal_z == 0 &&
       out_data.contact_x == 0 && out_data.contact_y == 0 &&
       out_data.contact_z == 0))
    else $error("nonzero fields without contact");

  // Normal components stay within unit range
  a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (out_data.normal_x <= NRM_ONE && out_data.normal_x >= -NRM_ONE &&
       out_data.normal_y <= NRM_ONE && out_data.normal_y >= -NRM_ONE &&
       out_data.normal_z <= NRM_ONE && out_data.normal_z >= -NRM_ONE))
    else $error("normal component out of range");

endmodule

bind sphere_envelope_contact sec_checker u_sec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
